// File: rtl/core/aemt_pkg.sv
// shared types and constants for the absolute encoder multi-turn tracker
// no dependencies

package aemt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TURN_BITS_DEF = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_RES_MASK  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEG_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR       = 2'd3;

  localparam logic [15:0] RES_MASK_RST  = 16'd8191;
  localparam logic [31:0] DEG_COUNT_RST = 32'd737370;
  localparam logic [15:0] RATE_RST      = 16'd1000;

  localparam logic [47:0] VEL_NEG_MAG   = 48'h8000_0000_0000;
  localparam logic [47:0] VEL_POS_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [48:0] VEL_UPPER_LIM = 49'd32768;

  typedef struct packed {
    logic load_in;
    logic scale;
    logic raw;
    logic pos;
    logic turn;
    logic update;
    logic multi;
    logic absv;
    logic vlo;
    logic vhi;
    logic sum;
    logic load_out;
  } cmd_t;

endpackage

// File: rtl/core/aemt_ctrl.sv
// sequencing state machine for the multi-turn tracker
// depends on aemt_pkg (cmd_t)

module aemt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output aemt_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_RAW,
    S_POS,
    S_TURN,
    S_UPDATE,
    S_MULTI,
    S_ABS,
    S_VLO,
    S_VHI,
    S_SUM,
    S_OUT
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = accept;
    cmd.scale    = (state == S_SCALE);
    cmd.raw      = (state == S_RAW);
    cmd.pos      = (state == S_POS);
    cmd.turn     = (state == S_TURN);
    cmd.update   = (state == S_UPDATE);
    cmd.multi    = (state == S_MULTI);
    cmd.absv     = (state == S_ABS);
    cmd.vlo      = (state == S_VLO);
    cmd.vhi      = (state == S_VHI);
    cmd.sum      = (state == S_SUM);
    cmd.load_out = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:   if (accept) state <= S_SCALE;
        S_SCALE:  state <= S_RAW;
        S_RAW:    state <= S_POS;
        S_POS:    state <= S_TURN;
        S_TURN:   state <= S_UPDATE;
        S_UPDATE: state <= S_MULTI;
        S_MULTI:  state <= S_ABS;
        S_ABS:    state <= S_VLO;
        S_VLO:    state <= S_VHI;
        S_VHI:    state <= S_SUM;
        S_SUM:    state <= S_OUT;
        S_OUT:    if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/aemt_datapath.sv
// configuration registers, tracking state and arithmetic of the tracker
// depends on aemt_pkg (cmd_t, register indexes, constants)

module aemt_datapath #(
  parameter int FRAC_BITS = aemt_pkg::FRAC_BITS_DEF,
  parameter int TURN_BITS = aemt_pkg::TURN_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  aemt_pkg::cmd_t                   cmd,
  input  logic                             cfg_write,
  input  logic [aemt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [aemt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [15:0]                      raw_word,
  input  logic                             operation,
  output logic signed [24:0]               angle_deg,
  output logic signed [40:0]               multi_turn_deg,
  output logic signed [15:0]               turn_count,
  output logic signed [47:0]               velocity
);

  localparam int SHIFT = 24 - FRAC_BITS;
  localparam int AW    = FRAC_BITS + 10;
  localparam int PW    = FRAC_BITS + 9;
  localparam int DW    = FRAC_BITS + 11;
  localparam int TPW   = 2 * PW;
  localparam int MW    = TURN_BITS + FRAC_BITS + 10;
  localparam int VW    = MW + 1;

  localparam logic [47:0]          FULL48     = 48'd360 << FRAC_BITS;
  localparam logic signed [DW-1:0] FULL_D     = DW'(360) <<< FRAC_BITS;
  localparam logic signed [DW-1:0] HALF_D     = DW'(180) <<< FRAC_BITS;
  localparam logic signed [DW-1:0] NEG_HALF_D = -HALF_D;
  localparam logic signed [PW-1:0] NEG_HALF_P = -(PW'(180) <<< FRAC_BITS);
  localparam logic signed [TPW-1:0] NEG_THRESH = -(TPW'(15000) <<< (2 * FRAC_BITS));
  localparam logic signed [MW-1:0] FULL_M     = MW'(360) <<< FRAC_BITS;

  // configuration
  logic [15:0] res_mask;
  logic [31:0] deg_count;
  logic [15:0] rate;
  logic        dir_neg;

  // tracking state
  logic signed [AW-1:0]        offset;
  logic signed [TURN_BITS-1:0] turns;
  logic signed [PW-1:0]        prev_angle;
  logic signed [MW-1:0]        prev_multi;

  // working registers
  logic [15:0]           raw_r;
  logic                  op_r;
  logic [47:0]           scale_prod;
  logic signed [AW-1:0]  raw_ang;
  logic signed [PW-1:0]  pos;
  logic signed [TPW-1:0] turn_prod;
  logic signed [MW-1:0]  multi;
  logic signed [VW-1:0]  diff;
  logic [63:0]           vmag;
  logic                  vneg;
  logic [47:0]           p_lo;
  logic [47:0]           p_hi;
  logic [47:0]           vm;

  logic [15:0]           counts;
  logic [47:0]           scaled;
  logic [47:0]           sat_mag;
  logic signed [AW-1:0]  raw_next;
  logic signed [AW-1:0]  off_sel;
  logic signed [DW-1:0]  d;
  logic signed [DW-1:0]  pos_wide;
  logic                  turn_hit;
  logic signed [MW-1:0]  multi_next;
  logic signed [VW-1:0]  diff_next;
  logic [48:0]           upper;
  logic                  over;
  logic [47:0]           vsat;
  logic signed [PW-1:0]  ang_o;
  logic signed [63:0]    ang64;
  logic signed [63:0]    multi64;
  logic signed [63:0]    turns64;

  assign counts   = raw_r & res_mask;
  assign scaled   = scale_prod >> SHIFT;
  assign sat_mag  = (scaled > FULL48) ? FULL48 : scaled;
  assign raw_next = -$signed(AW'(sat_mag));

  assign off_sel  = op_r ? raw_ang : offset;
  assign d        = DW'(raw_ang) - DW'(off_sel);

  always_comb begin
    if (d >= HALF_D) begin
      pos_wide = d - FULL_D;
    end else if (d < NEG_HALF_D) begin
      pos_wide = d + FULL_D;
    end else begin
      pos_wide = d;
    end
  end

  assign turn_hit   = (turn_prod < NEG_THRESH);
  assign multi_next = MW'(pos) + MW'(turns) * FULL_M;
  assign diff_next  = VW'(multi_next) - VW'(prev_multi);

  assign upper = 49'(p_hi) + 49'(p_lo[47:32]);
  assign over  = (upper > aemt_pkg::VEL_UPPER_LIM) ||
                 ((upper == aemt_pkg::VEL_UPPER_LIM) && (p_lo[31:0] != 32'd0));

  assign vsat    = (!vneg && vm[47]) ? aemt_pkg::VEL_POS_MAX : vm;
  assign ang_o   = !dir_neg ? pos : ((pos == NEG_HALF_P) ? pos : -pos);
  assign ang64   = 64'(ang_o);
  assign multi64 = dir_neg ? -64'(multi) : 64'(multi);
  assign turns64 = dir_neg ? -64'(turns) : 64'(turns);

  // configuration and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      res_mask   <= aemt_pkg::RES_MASK_RST;
      deg_count  <= aemt_pkg::DEG_COUNT_RST;
      rate       <= aemt_pkg::RATE_RST;
      dir_neg    <= 1'b0;
      offset     <= '0;
      turns      <= '0;
      prev_angle <= '0;
      prev_multi <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          aemt_pkg::REG_RES_MASK:  res_mask  <= cfg_data[15:0];
          aemt_pkg::REG_DEG_COUNT: deg_count <= cfg_data[31:0];
          aemt_pkg::REG_RATE:      rate      <= cfg_data[15:0];
          aemt_pkg::REG_DIR: begin
            dir_neg <= cfg_data[0];
            turns   <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.pos && op_r) begin
        offset <= raw_ang;
        turns  <= '0;
      end
      if (cmd.update && turn_hit) begin
        turns <= (pos < 0) ? turns + TURN_BITS'(1) : turns - TURN_BITS'(1);
      end
      if (cmd.multi) begin
        prev_angle <= pos;
        prev_multi <= multi_next;
      end
    end
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r <= raw_word;
      op_r  <= operation;
    end
    if (cmd.scale) scale_prod <= 48'(counts) * 48'(deg_count);
    if (cmd.raw)   raw_ang <= raw_next;
    if (cmd.pos)   pos <= PW'(pos_wide);
    if (cmd.turn)  turn_prod <= TPW'(pos) * TPW'(prev_angle);
    if (cmd.multi) begin
      multi <= multi_next;
      diff  <= diff_next;
    end
    if (cmd.absv) begin
      vmag <= (diff < 0) ? 64'(-diff) : 64'(diff);
      vneg <= (diff < 0) ^ dir_neg;
    end
    if (cmd.vlo) p_lo <= 48'(vmag[31:0]) * 48'(rate);
    if (cmd.vhi) p_hi <= 48'(vmag[63:32]) * 48'(rate);
    if (cmd.sum) vm <= over ? aemt_pkg::VEL_NEG_MAG : {upper[15:0], p_lo[31:0]};
    if (cmd.load_out) begin
      angle_deg      <= ang64[24:0];
      multi_turn_deg <= multi64[40:0];
      turn_count     <= turns64[15:0];
      velocity       <= vneg ? 48'd0 - vsat : vsat;
    end
  end

endmodule

// File: rtl/core/abs_encoder_multiturn_tracker.sv
// top level of the absolute encoder multi-turn tracker
// depends on aemt_pkg, aemt_ctrl, aemt_datapath
//
//   channel  handshake                  payload
//   input    in_valid / in_stall        raw_word, operation
//   output   out_valid / out_stall      angle_deg, multi_turn_deg, turn_count, velocity
//   config   cfg_write                  cfg_index, cfg_data
//
// one sample at a time: the result is registered once the sequencer has stepped the
// scale, wrap, turn product, multi-turn and velocity stages (velocity multiply takes
// two 32x16 passes), and waits while out_stall holds the previous result; next sample
// accepted on return to idle
// the result register holds under out_stall while the next sample is accepted
// rst is synchronous and restores register defaults and clears all tracking state

module abs_encoder_multiturn_tracker #(
  parameter int FRAC_BITS = aemt_pkg::FRAC_BITS_DEF,
  parameter int TURN_BITS = aemt_pkg::TURN_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      raw_word,
  input  logic                             operation,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [24:0]               angle_deg,
  output logic signed [40:0]               multi_turn_deg,
  output logic signed [15:0]               turn_count,
  output logic signed [47:0]               velocity,
  input  logic                             cfg_write,
  input  logic [aemt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [aemt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  aemt_pkg::cmd_t cmd;

  aemt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  aemt_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .TURN_BITS (TURN_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .raw_word       (raw_word),
    .operation      (operation),
    .angle_deg      (angle_deg),
    .multi_turn_deg (multi_turn_deg),
    .turn_count     (turn_count),
    .velocity       (velocity)
  );

endmodule

// File: rtl/core/aemt_checker.sv
// port-level assertions for the multi-turn tracker, bound to the top level
// depends on aemt_pkg and abs_encoder_multiturn_tracker

module aemt_checker #(
  parameter int FRAC_BITS = aemt_pkg::FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [24:0] angle_deg,
  input logic signed [40:0] multi_turn_deg,
  input logic signed [15:0] turn_count,
  input logic signed [47:0] velocity
);

  localparam logic signed [24:0] ANGLE_MIN = -25'sd11796480;
  localparam logic signed [24:0] ANGLE_MAX = 25'sd11796479;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(angle_deg) && $stable(multi_turn_deg) &&
                               $stable(turn_count) && $stable(velocity))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before sample finished");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in progress");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (FRAC_BITS != 16) || (angle_deg >= ANGLE_MIN && angle_deg <= ANGLE_MAX))
    else $error("single-turn angle outside half-turn range");

endmodule

bind abs_encoder_multiturn_tracker aemt_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);
